>>> sv/csrmeu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrmeu_pkg: shared types and codes of the matched entry update unit
// Payload structs, command and status codes, register indexes and default
// table sizes.
// ----------------------------------------------------------------------------
package csrmeu_pkg;

    localparam int ROWS_DEF    = 1024;
    localparam int ENTRIES_DEF = 4096;

    // command codes
    localparam logic [1:0] FUNC_LOAD_ROW   = 2'd0;
    localparam logic [1:0] FUNC_LOAD_ENTRY = 2'd1;
    localparam logic [1:0] FUNC_UPDATE     = 2'd2;
    localparam logic [1:0] FUNC_READ       = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_RANGE     = 2'd2;

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_SCALE  = 2'd1;
    localparam logic [1:0] REG_OFFSET = 2'd2;
    localparam logic [1:0] REG_LIMIT  = 2'd3;

    localparam int POS_W = 14;   // entry positions reachable from 13-bit row starts

    typedef struct packed {
        logic [1:0]         func;
        logic [12:0]        slot;
        logic [12:0]        start_req;
        logic [9:0]         row;
        logic [9:0]         col;
        logic signed [31:0] value;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] result_value;
        logic [11:0]        found_at;
    } out_t;

endpackage

>>> sv/csrmeu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrmeu_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module csrmeu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/csr_matched_entry_update_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_matched_entry_update_unit: sparse matrix entry search and update
// Holds a compressed-row sparse matrix and updates the entry at a given row
// and column by scaling it or by adding an offset with a zeroing threshold.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its one result
// appears on result for exactly one cycle with done high, and the receiver
// cannot stall it. Load row start and load entry finish at once: done rises
// the next cycle and busy stays low, so they run one per cycle. Read entry
// keeps busy high for one cycle. Update reads the row start and then the
// row end in ST_ROW0 and ST_ROW1, then scans the row one entry per cycle
// through the single read port of the entry memory, and on a match writes
// the new value back in ST_UPD. The state lives in two memories: a
// row-start table and an entry memory that packs column index and value,
// updated in place by read-modify-write.
// ----------------------------------------------------------------------------
module csr_matched_entry_update_unit #(
    parameter int ROWS    = csrmeu_pkg::ROWS_DEF,
    parameter int ENTRIES = csrmeu_pkg::ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // command channel
    input  logic              start,
    output logic              busy,
    input  csrmeu_pkg::in_t   cmd,
    // result channel
    output logic              done,
    output csrmeu_pkg::out_t  result,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    import csrmeu_pkg::*;

    localparam int RAW = $clog2(ROWS + 1);
    localparam int EAW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EW  = 42;              // {column, value}
    localparam logic [31:0] ROWS_W    = 32'(ROWS);
    localparam logic [31:0] ENTRIES_W = 32'(ENTRIES);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_ROW0 = 6'b000100,
        ST_ROW1 = 6'b001000,
        ST_SCAN = 6'b010000,
        ST_UPD  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic               mode_reg;
    logic signed [31:0] scale_reg;
    logic signed [31:0] offset_reg;
    logic signed [31:0] limit_reg;
    logic               cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            scale_reg  <= 32'sd65536;
            offset_reg <= 32'sd0;
            limit_reg  <= 32'sh7FFFFFFF;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                REG_MODE:   mode_reg   <= pwdata[0];
                REG_SCALE:  scale_reg  <= pwdata;
                REG_OFFSET: offset_reg <= pwdata;
                REG_LIMIT:  limit_reg  <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MODE:   prdata = {31'd0, mode_reg};
            REG_SCALE:  prdata = scale_reg;
            REG_OFFSET: prdata = offset_reg;
            REG_LIMIT:  prdata = limit_reg;
            default:    prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic             row_we;
    logic [RAW-1:0]   row_waddr, row_raddr;
    logic [12:0]      row_rdata;
    logic             ent_we;
    logic [EAW-1:0]   ent_waddr, ent_raddr;
    logic [EW-1:0]    ent_wdata, ent_rdata;

    csrmeu_ram #(
        .WIDTH (13),
        .DEPTH (ROWS + 1),
        .AW    (RAW)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (cmd.start_req),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    csrmeu_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES),
        .AW    (EAW)
    ) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // ------------------------------------------------------------------
    // Transaction state
    // ------------------------------------------------------------------
    logic [9:0]         row_reg, row_next;
    logic [9:0]         col_reg, col_next;
    logic [POS_W-1:0]   cur_reg, cur_next;   // entry position in flight
    logic [POS_W-1:0]   end_reg, end_next;   // first position past the row
    logic signed [63:0] prod_reg, prod_next;
    logic signed [32:0] sum_reg, sum_next;
    logic               done_reg, done_next;
    out_t               res_reg, res_next;

    logic               accept;
    logic [31:0]        slot_w, row_w, row1_w, cur_w, nxt_w, end_w, end_c;
    logic [POS_W-1:0]   nxt_pos;
    logic signed [31:0] ent_val;
    logic               col_hit;
    logic signed [64:0] rnd;
    logic signed [48:0] quo;
    logic signed [31:0] new_val;

    assign accept  = start && !busy;
    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign result  = res_reg;

    assign slot_w  = 32'(cmd.slot);
    assign row_w   = 32'(cmd.row);
    assign row1_w  = 32'(row_reg) + 32'd1;
    assign cur_w   = 32'(cur_reg);
    assign nxt_pos = cur_reg + POS_W'(1);
    assign nxt_w   = 32'(nxt_pos);
    assign end_w   = 32'(row_rdata);
    assign end_c   = (end_w > ENTRIES_W) ? ENTRIES_W : end_w;
    assign ent_val = ent_rdata[31:0];
    assign col_hit = (ent_rdata[41:32] == col_reg);

    // round to nearest, ties up, then saturate; offset path zeroes above limit
    assign rnd = 65'(prod_reg) + 65'sd32768;
    assign quo = 49'(rnd >>> 16);

    always_comb
    begin
        if (!mode_reg)
        begin
            if (quo > 49'sh0_7FFF_FFFF)
            begin
                new_val = 32'sh7FFFFFFF;
            end
            else if (quo < -49'sh0_8000_0000)
            begin
                new_val = 32'sh80000000;
            end
            else
            begin
                new_val = quo[31:0];
            end
        end
        else
        begin
            if (sum_reg > 33'(limit_reg))
            begin
                new_val = 32'sd0;
            end
            else if (sum_reg < -33'sh0_8000_0000)
            begin
                new_val = 32'sh80000000;
            end
            else
            begin
                new_val = sum_reg[31:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cur_next   = cur_reg;
        end_next   = end_reg;
        prod_next  = ent_val * scale_reg;
        sum_next   = 33'(ent_val) + 33'(offset_reg);
        done_next  = 1'b0;
        res_next   = res_reg;

        row_we     = 1'b0;
        row_waddr  = slot_w[RAW-1:0];
        row_raddr  = row_w[RAW-1:0];
        ent_we     = 1'b0;
        ent_waddr  = slot_w[EAW-1:0];
        ent_wdata  = {cmd.col, cmd.value};
        ent_raddr  = slot_w[EAW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    row_next = cmd.row;
                    col_next = cmd.col;
                    cur_next = POS_W'(cmd.slot);
                    res_next = '{status: STATUS_RANGE, result_value: 32'sd0, found_at: 12'd0};
                    unique case (cmd.func)
                        FUNC_LOAD_ROW:
                        begin
                            done_next = 1'b1;
                            if (slot_w <= ROWS_W)
                            begin
                                row_we          = 1'b1;
                                res_next.status = STATUS_OK;
                            end
                        end
                        FUNC_LOAD_ENTRY:
                        begin
                            done_next = 1'b1;
                            if (slot_w < ENTRIES_W)
                            begin
                                ent_we   = 1'b1;
                                res_next = '{status: STATUS_OK, result_value: cmd.value,
                                             found_at: cmd.slot[11:0]};
                            end
                        end
                        FUNC_READ:
                        begin
                            // issue the entry read, answer when data returns
                            if (slot_w < ENTRIES_W)
                            begin
                                state_next = ST_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        FUNC_UPDATE:
                        begin
                            // issue the read of the row start
                            if (row_w < ROWS_W)
                            begin
                                state_next = ST_ROW0;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                done_next  = 1'b1;
                res_next   = '{status: STATUS_OK, result_value: ent_val,
                               found_at: cur_reg[11:0]};
                state_next = ST_IDLE;
            end
            ST_ROW0:
            begin
                // row start is back; fetch the row end
                row_raddr  = row1_w[RAW-1:0];
                cur_next   = POS_W'(row_rdata);
                state_next = ST_ROW1;
            end
            ST_ROW1:
            begin
                end_next  = end_c[POS_W-1:0];
                ent_raddr = cur_w[EAW-1:0];
                if (cur_reg >= end_c[POS_W-1:0])
                begin
                    done_next  = 1'b1;
                    res_next   = '{status: STATUS_NOT_FOUND, result_value: 32'sd0,
                                   found_at: 12'd0};
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ent_raddr = nxt_w[EAW-1:0];
                if (col_hit)
                begin
                    state_next = ST_UPD;
                end
                else if (nxt_pos >= end_reg)
                begin
                    done_next  = 1'b1;
                    res_next   = '{status: STATUS_NOT_FOUND, result_value: 32'sd0,
                                   found_at: 12'd0};
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next = nxt_pos;
                end
            end
            ST_UPD:
            begin
                // write the new value back in place, column unchanged
                ent_we     = 1'b1;
                ent_waddr  = cur_w[EAW-1:0];
                ent_wdata  = {col_reg, new_val};
                done_next  = 1'b1;
                res_next   = '{status: STATUS_OK, result_value: new_val,
                               found_at: cur_reg[11:0]};
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        col_reg  <= col_next;
        cur_reg  <= cur_next;
        end_reg  <= end_next;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        res_reg  <= res_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a transaction is still in progress");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done || busy)
        else $error("accepted transaction neither finished nor in progress");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cur_reg < end_reg))
        else $error("row scan past the end of the row");

    a_upd_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> $past(state_reg == ST_SCAN))
        else $error("write-back without a matched entry");

endmodule
